// ===== sv/skvt_pkg.sv =====
// skvt_pkg: shared types and constants for the sorted key/value table.
// Operation and status codes, fixed field widths and the internal
// write-port and result structures. No dependencies.
package skvt_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 32;

    // Operation codes carried on the input channel
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_GET    = 2'd1,
        OP_SET    = 2'd2,
        OP_ERASE  = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Write side of the key and value memories
    typedef struct packed {
        logic             we_key;
        logic             we_val;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_mem_wr;

    // Finished result handed from the controller to the output register
    typedef struct packed {
        logic [VAL_W-1:0] value;
        t_status          status;
    } t_result;

endpackage

// ===== sv/skvt_if.sv =====
// skvt_if: valid/ready channel interfaces of the sorted key/value table.
// Depends on skvt_pkg for operation and status types.
interface skvt_in_if import skvt_pkg::*;;
    logic                    valid;
    logic                    ready;
    t_op                     operation;
    logic signed [KEY_W-1:0] key;
    logic        [VAL_W-1:0] value;

    modport source (output valid, output operation, output key, output value, input ready);
    modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface skvt_out_if import skvt_pkg::*; #(
    parameter int CNT_W = 7
);
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] result_value;
    t_status          status;
    logic [CNT_W-1:0] entry_count;

    modport source (output valid, output result_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input result_value, input status, input entry_count,
                    output ready);
endinterface

// ===== sv/skvt_ram.sv =====
// skvt_ram: generic single-write, single-read memory with registered read.
// No dependencies.
module skvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/skvt_ctrl.sv =====
// skvt_ctrl: operation sequencer of the sorted key/value table.
// Binary search over the key memory, then shift-up / shift-down passes.
// Depends on skvt_pkg and skvt_in_if.
module skvt_ctrl import skvt_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    skvt_in_if.sink                          i_in,
    // memory ports
    output logic [$clog2(CAPACITY)-1:0]      o_raddr,
    output logic [$clog2(CAPACITY)-1:0]      o_waddr,
    output t_mem_wr                          o_wr,
    input  logic [KEY_W-1:0]                 i_rd_key,
    input  logic [VAL_W-1:0]                 i_rd_val,
    // result toward the output register
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output t_result                          o_res,
    output logic [$clog2(CAPACITY+1)-1:0]    o_res_count
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_DECIDE,
        S_VRD,
        S_SHUP,
        S_SHDN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_val, n_val;
    logic [VAL_W-1:0] r_newval, n_newval;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_mid, n_mid;
    logic             r_hit, n_hit;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic [AW-1:0]    r_wa, n_wa;
    logic             r_wpend, n_wpend;
    logic [CNT_W-1:0] r_count, n_count;
    logic [VAL_W-1:0] r_res_value, n_res_value;
    t_status          r_res_status, n_res_status;

    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] w_mid;
    logic [CNT_W-1:0] w_ptr_dn;
    logic [CNT_W-1:0] w_ptr_up;
    logic             w_full;
    logic             w_right;

    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_sum[CNT_W:1];
    assign w_ptr_dn = r_ptr - CNT_W'(1);
    assign w_ptr_up = r_ptr + CNT_W'(1);
    assign w_full   = (r_count == CNT_W'(CAPACITY));

    // Insert searches past equal keys, the others stop at the first equal key
    assign w_right = (r_op == OP_INSERT) ? !($signed(r_key) < $signed(i_rd_key))
                                         : ($signed(i_rd_key) < $signed(r_key));

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.value  = r_res_value;
    assign o_res.status = r_res_status;
    assign o_res_count  = r_count;

    // Next-state and memory access logic
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_val        = r_val;
        n_newval     = r_newval;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_hit        = r_hit;
        n_ptr        = r_ptr;
        n_wa         = r_wa;
        n_wpend      = r_wpend;
        n_count      = r_count;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        o_raddr      = '0;
        o_waddr      = '0;
        o_wr         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op  = i_in.operation;
                    n_key = i_in.key;
                    n_val = i_in.value;
                    n_lo  = '0;
                    n_hi  = r_count;
                    n_hit = 1'b0;
                    if (i_in.operation == OP_INSERT && w_full) begin
                        n_res_value  = '0;
                        n_res_status = ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    o_raddr = w_mid[AW-1:0];
                    n_mid   = w_mid;
                    n_state = S_CMP;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_CMP: begin
                if (w_right) begin
                    n_lo = r_mid + CNT_W'(1);
                end else begin
                    n_hi  = r_mid;
                    n_hit = (i_rd_key == r_key);
                end
                n_state = S_SRCH;
            end
            S_DECIDE: begin
                n_ptr        = r_count;
                n_wpend      = 1'b0;
                n_res_status = ST_OK;
                if (r_op == OP_INSERT) begin
                    n_newval    = r_val;
                    n_res_value = r_val;
                    n_state     = S_SHUP;
                end else if (r_hit) begin
                    if (r_op == OP_SET) begin
                        o_wr.we_val = 1'b1;
                        o_wr.val    = r_val;
                        o_waddr     = r_lo[AW-1:0];
                        n_res_value = r_val;
                        n_state     = S_DONE;
                    end else begin
                        // get or erase: fetch the stored handle
                        o_raddr = r_lo[AW-1:0];
                        n_state = S_VRD;
                    end
                end else if (r_op == OP_ERASE) begin
                    n_res_value  = '0;
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else if (w_full) begin
                    n_res_value  = '0;
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    // create: null handle for get, new handle for set
                    n_newval    = (r_op == OP_SET) ? r_val : '0;
                    n_res_value = (r_op == OP_SET) ? r_val : '0;
                    n_state     = S_SHUP;
                end
            end
            S_VRD: begin
                n_res_value = i_rd_val;
                if (r_op == OP_ERASE) begin
                    n_ptr   = r_lo;
                    n_wpend = 1'b0;
                    n_state = S_SHDN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHUP: begin
                // move entries up by one, top first, then store the new one
                if (r_wpend) begin
                    o_wr.we_key = 1'b1;
                    o_wr.we_val = 1'b1;
                    o_wr.key    = i_rd_key;
                    o_wr.val    = i_rd_val;
                    o_waddr     = r_wa;
                end
                if (r_ptr > r_lo) begin
                    o_raddr = w_ptr_dn[AW-1:0];
                    n_wa    = r_ptr[AW-1:0];
                    n_ptr   = w_ptr_dn;
                    n_wpend = 1'b1;
                end else begin
                    n_wpend = 1'b0;
                    if (!r_wpend) begin
                        o_wr.we_key = 1'b1;
                        o_wr.we_val = 1'b1;
                        o_wr.key    = r_key;
                        o_wr.val    = r_newval;
                        o_waddr     = r_lo[AW-1:0];
                        n_count     = r_count + CNT_W'(1);
                        n_state     = S_DONE;
                    end
                end
            end
            S_SHDN: begin
                // move entries above the removed one down by one
                if (r_wpend) begin
                    o_wr.we_key = 1'b1;
                    o_wr.we_val = 1'b1;
                    o_wr.key    = i_rd_key;
                    o_wr.val    = i_rd_val;
                    o_waddr     = r_wa;
                end
                if (w_ptr_up < r_count) begin
                    o_raddr = w_ptr_up[AW-1:0];
                    n_wa    = r_ptr[AW-1:0];
                    n_ptr   = w_ptr_up;
                    n_wpend = 1'b1;
                end else begin
                    n_wpend = 1'b0;
                    if (!r_wpend) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_wpend      <= n_wpend;
            r_op         <= n_op;
            r_key        <= n_key;
            r_val        <= n_val;
            r_newval     <= n_newval;
            r_lo         <= n_lo;
            r_hi         <= n_hi;
            r_mid        <= n_mid;
            r_hit        <= n_hit;
            r_ptr        <= n_ptr;
            r_wa         <= n_wa;
            r_res_value  <= n_res_value;
            r_res_status <= n_res_status;
        end
    end

endmodule

// ===== sv/sorted_key_value_table.sv =====
// sorted_key_value_table: top level of the sorted key/value table.
// Holds the key and value memories (skvt_ram), the sequencer (skvt_ctrl)
// and the result output register. Depends on skvt_pkg and skvt_if.
//
//   channel | direction | transfer contents
//   --------+-----------+-----------------------------------------------
//   i_in    | in        | operation, key, value
//   o_out   | out       | result_value, status, entry_count
//
// Steps per transfer: accept, up to ceil(log2(n+1)) search probes for n stored
// entries (each a read and a compare), decision and result. A get or erase hit
// first reads back the stored handle; insert or create moves the entries above
// the slot up and stores the new one; erase moves the entries above the removed
// one down. Insert into a full table goes straight from accept to result.
// Reset clears the entry count and the sequencer; memory contents are not
// cleared. A finished result waits in the output register while the next
// transfer is accepted; with that register full the sequencer holds its
// result and the input stalls.
module sorted_key_value_table import skvt_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    skvt_in_if.sink    i_in,
    skvt_out_if.source o_out
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [AW-1:0]    w_raddr;
    logic [AW-1:0]    w_waddr;
    t_mem_wr          w_wr;
    logic [KEY_W-1:0] w_rd_key;
    logic [VAL_W-1:0] w_rd_val;
    logic             w_res_valid;
    logic             w_res_ready;
    t_result          w_res;
    logic [CNT_W-1:0] w_res_count;

    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    t_status          r_out_status;
    logic [CNT_W-1:0] r_out_count;

    skvt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_raddr     (w_raddr),
        .o_waddr     (w_waddr),
        .o_wr        (w_wr),
        .i_rd_key    (w_rd_key),
        .i_rd_val    (w_rd_val),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_res_count (w_res_count)
    );

    // Key memory
    skvt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.we_key),
        .i_waddr (w_waddr),
        .i_wdata (w_wr.key),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_key)
    );

    // Value memory
    skvt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.we_val),
        .i_waddr (w_waddr),
        .i_wdata (w_wr.val),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_val)
    );

    // Output register: loads when empty or when its transfer completes
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_res_ready) begin
                r_out_valid <= w_res_valid;
            end
            if (w_res_valid && w_res_ready) begin
                r_out_value  <= w_res.value;
                r_out_status <= w_res.status;
                r_out_count  <= w_res_count;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.status       = r_out_status;
    assign o_out.entry_count  = r_out_count;

endmodule
